>>> rtl/lrukr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU-K frame replacer.
// Holds the request/response word layouts, config layout and operation codes.
package lrukr_pkg;

	// Field widths fixed by the interface
	localparam int FRAME_W  = 10;
	localparam int HITS_W   = 4;
	localparam int THRESH_W = 4;
	localparam int CAP_W    = 5;
	localparam int COUNT_W  = 5;
	localparam int FUNC_W   = 2;

	// APB port geometry
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Access count saturates here
	localparam logic [HITS_W-1:0] HITS_MAX = 4'd15;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_ACCESS    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SET_EVICT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE    = 2'd2;
	localparam logic [FUNC_W-1:0] FN_EVICT     = 2'd3;

	// Register index, taken from paddr[2]
	localparam logic REG_THRESH = 1'b0;
	localparam logic REG_CAP    = 1'b1;

	// Register reset values
	localparam logic [THRESH_W-1:0] THRESH_RST = 4'd2;
	localparam logic [CAP_W-1:0]    CAP_RST    = 5'd16;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [FRAME_W-1:0] frame_no;
		logic               evictable;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [FRAME_W-1:0] victim_frame;
		logic [COUNT_W-1:0] evictable_count;
	} rsp_t;

	typedef struct packed {
		logic [THRESH_W-1:0] access_threshold;
		logic [CAP_W-1:0]    capacity;
	} cfg_t;

endpackage

>>> rtl/lrukr_regs.sv
`timescale 1ns / 1ps
// APB configuration registers: access threshold and capacity.
// Depends on lrukr_pkg.
module lrukr_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lrukr_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lrukr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lrukr_pkg::APB_DATA_W-1:0]   prdata,
	output logic                               pready,
	output lrukr_pkg::cfg_t                    cfg
);
	import lrukr_pkg::*;

	logic [THRESH_W-1:0] thresh_q;
	logic [CAP_W-1:0]    cap_q;
	logic                wr_en;
	logic                reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];

	// register write, word aligned decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
			cap_q    <= CAP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_THRESH: thresh_q <= pwdata[THRESH_W-1:0];
				REG_CAP:    cap_q    <= pwdata[CAP_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_THRESH: prdata = APB_DATA_W'(thresh_q);
			REG_CAP:    prdata = APB_DATA_W'(cap_q);
		endcase
	end

	assign cfg.access_threshold = thresh_q;
	assign cfg.capacity         = cap_q;

endmodule

>>> rtl/lrukr_engine.sv
`timescale 1ns / 1ps
// Slot table and sequencer: scans the slot memory once to find the frame,
// a free slot and the victims, then, when ranks change, sweeps it to renumber recency ranks.
// Depends on lrukr_pkg.
module lrukr_engine #(
	parameter int ENTRIES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lrukr_pkg::req_t req,
	input  lrukr_pkg::cfg_t cfg,
	output logic            idle,
	output logic            res_valid,
	input  logic            res_ready,
	output lrukr_pkg::rsp_t res
);
	import lrukr_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SWEEP  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [HITS_W-1:0]  hits;
		logic               can_evict;
		logic               promoted;
		logic [IDX_W-1:0]   rank;
	} slot_t;

	function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

	logic [2:0]         state_q;
	req_t               op_q;

	// slot memory and its read pipeline
	slot_t              mem_q [ENTRIES];
	logic               mem_re;
	logic [IDX_W-1:0]   mem_raddr;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	slot_t              mem_wdata;
	slot_t              rdata_s1;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [IDX_W-1:0]   iss_q;
	logic               iss_done_q;

	// table state
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   used_q;
	logic [CNT_W-1:0]   hist_q;
	logic [CNT_W-1:0]   cach_q;

	// scan findings
	logic               hit_q, free_q, bh_q, bc_q;
	logic [IDX_W-1:0]   hit_idx_q, free_idx_q, bh_idx_q, bc_idx_q;
	slot_t              hit_ent_q, bh_ent_q, bc_ent_q;

	// sweep plan
	logic               drop_en_q, touch_en_q, ins_en_q, spec_en_q;
	logic [IDX_W-1:0]   drop_rank_q, touch_rank_q, spec_idx_q;
	slot_t              spec_ent_q;
	logic               res_ok_q;
	logic [FRAME_W-1:0] res_victim_q;

	logic               start_go;
	logic               scan_data, sweep_data;
	slot_t              cur;
	logic               cur_v;
	logic               take_hit, take_free, take_bh, take_bc;

	// decide-cycle plan
	logic               vic_found;
	logic [IDX_W-1:0]   vic_idx;
	slot_t              vic_ent;
	logic               need_evict;
	logic [HITS_W-1:0]  new_hits;
	logic               p_ok, p_sweep, p_drop, p_touch, p_ins, p_spec, p_clr, p_set;
	logic               p_dec, p_dec_cached;
	logic [IDX_W-1:0]   p_drop_rank, p_touch_rank, p_spec_idx, p_clr_idx;
	slot_t              p_spec_ent;
	logic [FRAME_W-1:0] p_victim;
	logic [CNT_W-1:0]   p_hist, p_cach, p_used;

	// sweep rank update
	logic [IDX_W-1:0]   sw_rank;
	slot_t              sw_ent;
	logic [CNT_W:0]     ev_sum;

	assign start_go   = (state_q == ST_IDLE) && start;
	assign scan_data  = (state_q == ST_SCAN) && rd_vld_s1;
	assign sweep_data = (state_q == ST_SWEEP) && rd_vld_s1;
	assign cur        = rdata_s1;
	assign cur_v      = valid_q[rd_idx_s1];

	// memory read issue
	assign mem_re    = ((state_q == ST_SCAN) || (state_q == ST_SWEEP)) && !iss_done_q;
	assign mem_raddr = iss_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_s1 <= mem_q[mem_raddr];
	end

	// issue counter and read pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q      <= '0;
			iss_done_q <= 1'b1;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			rd_vld_s1 <= mem_re;
			rd_idx_s1 <= iss_q;
			if (start_go || (state_q == ST_DECIDE)) begin
				iss_q      <= '0;
				iss_done_q <= 1'b0;
			end else if (mem_re) begin
				if (iss_q == LAST_IDX)
					iss_done_q <= 1'b1;
				else
					iss_q <= iss_q + 1'b1;
			end
		end
	end

	// scan compare: frame match, first free slot, oldest evictable per group
	assign take_hit  = scan_data && cur_v && (cur.frame == op_q.frame_no) && !hit_q;
	assign take_free = scan_data && !cur_v && !free_q;
	assign take_bh   = scan_data && cur_v && cur.can_evict && !cur.promoted &&
			   (!bh_q || (cur.rank > bh_ent_q.rank));
	assign take_bc   = scan_data && cur_v && cur.can_evict && cur.promoted &&
			   (!bc_q || (cur.rank > bc_ent_q.rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			bh_q       <= 1'b0;
			bc_q       <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			bh_idx_q   <= '0;
			bc_idx_q   <= '0;
		end else if (start_go) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			bh_q   <= 1'b0;
			bc_q   <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
			end
			if (take_free) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (take_bh) begin
				bh_q     <= 1'b1;
				bh_idx_q <= rd_idx_s1;
			end
			if (take_bc) begin
				bc_q     <= 1'b1;
				bc_idx_q <= rd_idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_go)
			op_q <= req;
		if (take_hit)
			hit_ent_q <= cur;
		if (take_bh)
			bh_ent_q <= cur;
		if (take_bc)
			bc_ent_q <= cur;
	end

	// victim choice: history group first, then cached
	assign vic_found = bh_q || bc_q;
	assign vic_idx   = bh_q ? bh_idx_q : bc_idx_q;
	assign vic_ent   = bh_q ? bh_ent_q : bc_ent_q;
	assign need_evict = (CMP_W'(used_q) >= CMP_W'(cfg.capacity)) || (used_q == FULL_CNT);
	assign new_hits  = (hit_ent_q.hits == HITS_MAX) ? hit_ent_q.hits : hit_ent_q.hits + 1'b1;

	// decide: what this operation changes
	always_comb begin
		p_ok         = 1'b0;
		p_sweep      = 1'b0;
		p_drop       = 1'b0;
		p_touch      = 1'b0;
		p_ins        = 1'b0;
		p_spec       = 1'b0;
		p_clr        = 1'b0;
		p_set        = 1'b0;
		p_dec        = 1'b0;
		p_dec_cached = 1'b0;
		p_drop_rank  = '0;
		p_touch_rank = '0;
		p_spec_idx   = hit_idx_q;
		p_clr_idx    = vic_idx;
		p_spec_ent   = hit_ent_q;
		p_victim     = '0;
		p_hist       = hist_q;
		p_cach       = cach_q;
		p_used       = used_q;
		unique case (op_q.func)
			FN_ACCESS: begin
				if (hit_q) begin
					// known frame: count, maybe promote, make most recent
					p_ok            = 1'b1;
					p_sweep         = 1'b1;
					p_touch         = 1'b1;
					p_spec          = 1'b1;
					p_touch_rank    = hit_ent_q.rank;
					p_spec_ent.rank = '0;
					if (!hit_ent_q.promoted) begin
						p_spec_ent.hits = new_hits;
						if (new_hits == cfg.access_threshold) begin
							p_spec_ent.promoted = 1'b1;
							if (hit_ent_q.can_evict) begin
								p_hist = dec_sat(hist_q);
								p_cach = cach_q + 1'b1;
							end
						end
					end
				end else if (!need_evict || vic_found) begin
					// new frame, evicting first when at capacity
					p_ok                 = 1'b1;
					p_sweep              = 1'b1;
					p_ins                = 1'b1;
					p_spec               = 1'b1;
					p_set                = 1'b1;
					p_used               = used_q + 1'b1;
					p_spec_idx           = free_idx_q;
					p_spec_ent.frame     = op_q.frame_no;
					p_spec_ent.hits      = HITS_W'(1);
					p_spec_ent.can_evict = 1'b0;
					p_spec_ent.promoted  = 1'b0;
					p_spec_ent.rank      = '0;
					if (need_evict) begin
						p_drop       = 1'b1;
						p_drop_rank  = vic_ent.rank;
						p_clr        = 1'b1;
						p_dec        = 1'b1;
						p_dec_cached = vic_ent.promoted;
						p_used       = used_q;
						if (!(free_q && (free_idx_q < vic_idx)))
							p_spec_idx = vic_idx;
					end
				end
			end
			FN_SET_EVICT: begin
				if (hit_q && (hit_ent_q.can_evict != op_q.evictable)) begin
					p_spec               = 1'b1;
					p_spec_ent.can_evict = op_q.evictable;
					if (hit_ent_q.promoted)
						p_cach = op_q.evictable ? cach_q + 1'b1 : dec_sat(cach_q);
					else
						p_hist = op_q.evictable ? hist_q + 1'b1 : dec_sat(hist_q);
				end
			end
			FN_REMOVE: begin
				if (hit_q) begin
					p_sweep      = 1'b1;
					p_drop       = 1'b1;
					p_drop_rank  = hit_ent_q.rank;
					p_clr        = 1'b1;
					p_clr_idx    = hit_idx_q;
					p_used       = used_q - 1'b1;
					p_dec        = hit_ent_q.can_evict;
					p_dec_cached = hit_ent_q.promoted;
				end
			end
			FN_EVICT: begin
				if (vic_found) begin
					p_ok         = 1'b1;
					p_victim     = vic_ent.frame;
					p_sweep      = 1'b1;
					p_drop       = 1'b1;
					p_drop_rank  = vic_ent.rank;
					p_clr        = 1'b1;
					p_used       = used_q - 1'b1;
					p_dec        = 1'b1;
					p_dec_cached = vic_ent.promoted;
				end
			end
		endcase
		// a dropped evictable slot leaves its group count
		if (p_dec) begin
			if (p_dec_cached)
				p_cach = dec_sat(p_cach);
			else
				p_hist = dec_sat(p_hist);
		end
	end

	// sweep: renumber ranks of valid slots, place the touched/new slot
	always_comb begin
		sw_rank = cur.rank;
		if (drop_en_q && (sw_rank > drop_rank_q))
			sw_rank = sw_rank - 1'b1;
		if (ins_en_q)
			sw_rank = sw_rank + 1'b1;
		if (touch_en_q && (cur.rank < touch_rank_q))
			sw_rank = sw_rank + 1'b1;
		sw_ent      = cur;
		sw_ent.rank = sw_rank;
		if (spec_en_q && (rd_idx_s1 == spec_idx_q))
			sw_ent = spec_ent_q;
	end

	// memory write port: sweep writes, or single write for set evictable
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = sw_ent;
		if (sweep_data) begin
			mem_we = cur_v;
		end else if ((state_q == ST_DECIDE) && p_spec && !p_sweep) begin
			mem_we    = 1'b1;
			mem_waddr = p_spec_idx;
			mem_wdata = p_spec_ent;
		end
	end

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			used_q       <= '0;
			hist_q       <= '0;
			cach_q       <= '0;
			drop_en_q    <= 1'b0;
			touch_en_q   <= 1'b0;
			ins_en_q     <= 1'b0;
			spec_en_q    <= 1'b0;
			drop_rank_q  <= '0;
			touch_rank_q <= '0;
			spec_idx_q   <= '0;
			res_ok_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_data && (rd_idx_s1 == LAST_IDX))
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					drop_en_q    <= p_drop;
					touch_en_q   <= p_touch;
					ins_en_q     <= p_ins;
					spec_en_q    <= p_spec && p_sweep;
					drop_rank_q  <= p_drop_rank;
					touch_rank_q <= p_touch_rank;
					spec_idx_q   <= p_spec_idx;
					res_ok_q     <= p_ok;
					used_q       <= p_used;
					hist_q       <= p_hist;
					cach_q       <= p_cach;
					if (p_clr)
						valid_q[p_clr_idx] <= 1'b0;
					if (p_set)
						valid_q[p_spec_idx] <= 1'b1;
					state_q <= p_sweep ? ST_SWEEP : ST_DONE;
				end
				ST_SWEEP: begin
					if (sweep_data && (rd_idx_s1 == LAST_IDX))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			spec_ent_q   <= p_spec_ent;
			res_victim_q <= p_victim;
		end
	end

	// result word
	assign ev_sum              = {1'b0, hist_q} + {1'b0, cach_q};
	assign idle                = (state_q == ST_IDLE);
	assign res_valid           = (state_q == ST_DONE);
	assign res.ok              = res_ok_q;
	assign res.victim_frame    = res_victim_q;
	assign res.evictable_count = COUNT_W'(ev_sum);

	// group counts never exceed the slots in use
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ev_sum <= {1'b0, used_q})
		else $error("evictable counts exceed used slots");

	// used count tracks the valid bits
	a_used_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(used_q))
		else $error("used count out of step with valid bits");

	// the sequencer leaves idle only on a start
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && !start |=> (state_q == ST_IDLE))
		else $error("left idle without a word");

	// sweep writes only land on live slots
	a_sweep_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) && mem_we |-> valid_q[mem_waddr])
		else $error("sweep wrote an empty slot");

endmodule

>>> rtl/lru_k_frame_replacer.sv
`timescale 1ns / 1ps
// LRU-K frame replacer top level: request/response handshakes, result
// register and APB config. Depends on lrukr_pkg, lrukr_regs, lrukr_engine.
//
// Each request word is handled alone: the engine first scans all ENTRIES
// slots of its slot memory, one per cycle, to find the named frame, a free
// slot and the oldest evictable frame of each group, then decides in the
// DECIDE state, and when recency ranks change (access, remove, evict with a
// victim) sweeps the memory once more, one slot per cycle, rewriting ranks.
// The single read port of the slot memory makes the scan and the sweep
// visit the slots one at a time. The response sits in an output register,
// so a new request is taken while it waits. Valid bits are flip-flops
// cleared at reset; slot contents need no clearing pass.
module lru_k_frame_replacer #(
	parameter int ENTRIES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             req_valid,
	output logic                             req_ready,
	input  lrukr_pkg::req_t                  req,
	// response channel
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output lrukr_pkg::rsp_t                  rsp,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lrukr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lrukr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lrukr_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready
);
	import lrukr_pkg::*;

	cfg_t cfg;
	logic eng_idle;
	logic eng_start;
	logic res_valid;
	logic res_ready;
	rsp_t res;
	logic rsp_valid_q;
	rsp_t rsp_q;

	lrukr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign req_ready = eng_idle;
	assign eng_start = req_valid & req_ready;

	lrukr_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (eng_start),
		.req       (req),
		.cfg       (cfg),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: loads when empty or being drained
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
